// ===== rtl/triangle_bbox_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the triangle bounding-box rasterizer
// Each macro expects clk and rst_n in scope of the asserting module.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_BBOX_RASTERIZER_DEFINES_SVH
`define TRIANGLE_BBOX_RASTERIZER_DEFINES_SVH

// Check a consequent in the same cycle as the antecedent
`define TBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after the antecedent
`define TBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tbr_pkg.sv =====
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared types and constants of the triangle bounding-box rasterizer.
// ----------------------------------------------------------------------------
package tbr_pkg;

  localparam int VTX_W      = 16;
  localparam int PIX_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int AD_W       = 36;
  localparam int INV_W      = 40;
  localparam int CHUNK_W    = 17;
  localparam int MUL_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH     = 2'd2;

  // vertex store slots
  localparam int V_AX = 0;
  localparam int V_AY = 1;
  localparam int V_AZ = 2;
  localparam int V_BX = 3;
  localparam int V_BY = 4;
  localparam int V_BZ = 5;
  localparam int V_CX = 6;
  localparam int V_CY = 7;
  localparam int V_CZ = 8;

  typedef struct packed {
    logic                    action;
    logic signed [VTX_W-1:0] vertex_a_x;
    logic signed [VTX_W-1:0] vertex_a_y;
    logic signed [VTX_W-1:0] vertex_a_z;
    logic signed [VTX_W-1:0] vertex_b_x;
    logic signed [VTX_W-1:0] vertex_b_y;
    logic signed [VTX_W-1:0] vertex_b_z;
    logic signed [VTX_W-1:0] vertex_c_x;
    logic signed [VTX_W-1:0] vertex_c_y;
    logic signed [VTX_W-1:0] vertex_c_z;
  } tbr_in_t;

  typedef struct packed {
    logic                    covered;
    logic [PIX_W-1:0]        pixel_x;
    logic [PIX_W-1:0]        pixel_y;
    logic signed [VTX_W-1:0] depth;
    logic                    last;
  } tbr_out_t;

  // status of the reciprocal unit
  typedef struct packed {
    logic             done;
    logic [INV_W-1:0] quot;
  } tbr_recip_stat_t;

endpackage

// ===== rtl/tbr_in_if.sv =====
// ----------------------------------------------------------------------------
// tbr_in_if
// Request channel of the rasterizer: valid, ready and one request payload.
// ----------------------------------------------------------------------------
interface tbr_in_if;
  import tbr_pkg::*;

  logic    valid;
  logic    ready;
  tbr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tbr_out_if.sv =====
// ----------------------------------------------------------------------------
// tbr_out_if
// Result channel of the rasterizer: valid, ready and one pixel result.
// ----------------------------------------------------------------------------
interface tbr_out_if;
  import tbr_pkg::*;

  logic     valid;
  logic     ready;
  tbr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tbr_recip.sv =====
// ----------------------------------------------------------------------------
// tbr_recip
// Restoring divider for floor(2^FRAC_BITS / divisor), one quotient bit a cycle,
// saturated to the inverse-area width. A zero divisor returns zero.
// ----------------------------------------------------------------------------
module tbr_recip #(
  parameter int FRAC_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [tbr_pkg::AD_W-1:0] divisor,
  output tbr_pkg::tbr_recip_stat_t stat
);
  import tbr_pkg::*;

  localparam int QW = (FRAC_BITS + 1 > INV_W + 1) ? FRAC_BITS + 1 : INV_W + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [AD_W:0]     rem_r;
  logic [QW-1:0]     q_r;
  logic [AD_W-1:0]   div_r;
  logic [INV_W-1:0]  quot_r;
  logic              num_bit;
  logic [AD_W:0]     rem_sh;
  logic              ge;
  logic [AD_W:0]     rem_nxt;
  logic [QW-1:0]     q_nxt;
  logic [INV_W-1:0]  quot_nxt;

  // shift in the numerator bit, trial subtract
  always_comb begin
    num_bit  = (cnt_r == CW'(FRAC_BITS));
    rem_sh   = {rem_r[AD_W-1:0], num_bit};
    ge       = (rem_sh >= {1'b0, div_r});
    rem_nxt  = ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
    q_nxt    = {q_r[QW-2:0], ge};
    quot_nxt = (|q_nxt[QW-1:INV_W]) ? {INV_W{1'b1}} : q_nxt[INV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (divisor == '0) begin
          done_r <= 1'b1;
          quot_r <= '0;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(FRAC_BITS);
          rem_r  <= '0;
          q_r    <= '0;
          div_r  <= divisor;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= quot_nxt;
        end
      end
    end
  end

  assign stat.done = done_r;
  assign stat.quot = quot_r;

endmodule

// ===== rtl/triangle_bbox_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_bbox_rasterizer
// Bounding-box triangle walker with edge tests and barycentric depth.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries requests. A load request stores three vertices, sets the
//   screen-clamped bounding box and computes the inverse doubled area; it
//   gives no result. A step request visits the next point of the box (x
//   outer, y inner) and gives one result on out_chan; a step with no walk in
//   progress gives nothing. cfg_we/cfg_index/cfg_wdata write the screen size
//   and depth limit; the user writes them only while idle (not enforced).
// Datapath:
//   One request at a time on a single 18x18 multiplier. A load waits for the
//   bit-serial reciprocal divider. A step for a point outside the triangle,
//   or after a zero-area load, forms only the edge products; any other
//   step adds the partial products for the weights and the depth products.
// Reset and stall:
//   Reset clears the walk, the inverse area and the registers to 80x24 and
//   the largest depth. A result waits in the output register while the
//   receiver stalls; the next request is taken meanwhile and its result
//   holds in the final state until the output register is free.
// ----------------------------------------------------------------------------
module triangle_bbox_rasterizer #(
  parameter int MAX_SCREEN      = 4096,
  parameter int RECIP_FRAC_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tbr_in_if.sink                         in_chan,
  tbr_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [tbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tbr_pkg::*;

  localparam int AW   = RECIP_FRAC_BITS + 2;
  localparam int WLSB = RECIP_FRAC_BITS - 16;
  localparam logic [SIZE_W-1:0] SCR_LIM =
    (MAX_SCREEN < 4096) ? SIZE_W'(MAX_SCREEN) : SIZE_W'(4096);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_AREA, S_DIV, S_EDGE, S_WGT, S_DEPTH, S_FIN
  } state_t;

  state_t                  state_r;
  logic                    act_r;
  logic                    ph_r;
  logic [2:0]              op_r;
  logic [1:0]              wi_r;
  logic [1:0]              ia_r;
  logic [1:0]              ib_r;

  logic [SIZE_W-1:0]       scr_w_r;
  logic [SIZE_W-1:0]       scr_h_r;
  logic signed [VTX_W-1:0] max_depth_r;

  logic signed [VTX_W-1:0] vtx_r [9];
  logic [INV_W-1:0]        inv_r;
  logic [PIX_W-1:0]        scan_x_r;
  logic [PIX_W-1:0]        scan_y_r;
  logic [PIX_W-1:0]        box_min_y_r;
  logic [PIX_W-1:0]        box_max_x_r;
  logic [PIX_W-1:0]        box_max_y_r;
  logic                    walking_r;

  logic signed [35:0]      prod_r;
  logic signed [36:0]      acc_r;
  logic signed [36:0]      c_r [3];
  logic [AW-1:0]           wacc_r;
  logic [CHUNK_W-1:0]      w_r [3];
  logic signed [35:0]      dsum_r;

  logic                    recip_start_r;
  logic [AD_W-1:0]         div_in_r;
  tbr_recip_stat_t         recip_stat;

  logic                    out_valid_r;
  tbr_out_t                out_r;

  // datapath nets
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [35:0]      prod;
  logic signed [MUL_W-1:0] px_s;
  logic signed [MUL_W-1:0] py_s;
  logic signed [VTX_W-1:0] ux, uy, vx, vy;
  logic signed [36:0]      csel;
  logic [36:0]             cabs;
  logic [50:0]             a_pad;
  logic [50:0]             i_pad;
  logic [CHUNK_W-1:0]      a_chunk;
  logic [CHUNK_W-1:0]      i_chunk;
  logic [2:0]              sh_sel;
  logic [101:0]            pp_ext;
  logic [101:0]            pp_sh;
  logic [AW-1:0]           wsum;
  logic signed [36:0]      area_d;
  logic [36:0]             area_abs;
  logic                    in_tri;
  logic                    go;
  logic signed [35:0]      dfull;
  logic signed [VTX_W-1:0] dclamp;
  logic                    last_pt;

  // bounding-box nets
  logic signed [VTX_W-1:0] xmin, xmax, ymin, ymax;
  logic signed [PIX_W:0]   fx0, fx1, fy0, fy1;
  logic [SIZE_W-1:0]       lim_w, lim_h;
  logic signed [SIZE_W:0]  wm1, hm1;
  logic [PIX_W-1:0]        bx0, bx1, by0, by1;
  logic                    box_off;

  // shared multiplier
  assign prod = mul_a * mul_b;

  // select edge endpoints
  always_comb begin
    case (op_r[2:1])
      2'd0: begin
        ux = vtx_r[V_AX]; uy = vtx_r[V_AY]; vx = vtx_r[V_BX]; vy = vtx_r[V_BY];
      end
      2'd1: begin
        ux = vtx_r[V_BX]; uy = vtx_r[V_BY]; vx = vtx_r[V_CX]; vy = vtx_r[V_CY];
      end
      default: begin
        ux = vtx_r[V_CX]; uy = vtx_r[V_CY]; vx = vtx_r[V_AX]; vy = vtx_r[V_AY];
      end
    endcase
  end

  // slice weight operands into 17-bit chunks
  always_comb begin
    case (wi_r)
      2'd0:    csel = c_r[1];
      2'd1:    csel = c_r[2];
      default: csel = c_r[0];
    endcase
    cabs  = (csel < 0) ? 37'(-csel) : 37'(csel);
    a_pad = {15'b0, cabs[35:0]};
    i_pad = {11'b0, inv_r};
    case (ia_r)
      2'd0:    a_chunk = a_pad[16:0];
      2'd1:    a_chunk = a_pad[33:17];
      default: a_chunk = a_pad[50:34];
    endcase
    case (ib_r)
      2'd0:    i_chunk = i_pad[16:0];
      2'd1:    i_chunk = i_pad[33:17];
      default: i_chunk = i_pad[50:34];
    endcase
  end

  // multiplier operands per sequencer step
  always_comb begin
    px_s  = {2'b00, scan_x_r, 4'b0000};
    py_s  = {2'b00, scan_y_r, 4'b0000};
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_AREA: begin
        if (!op_r[0]) begin
          mul_a = MUL_W'(vtx_r[V_BX]) - MUL_W'(vtx_r[V_AX]);
          mul_b = MUL_W'(vtx_r[V_CY]) - MUL_W'(vtx_r[V_AY]);
        end else begin
          mul_a = MUL_W'(vtx_r[V_BY]) - MUL_W'(vtx_r[V_AY]);
          mul_b = MUL_W'(vtx_r[V_CX]) - MUL_W'(vtx_r[V_AX]);
        end
      end
      S_EDGE: begin
        if (!op_r[0]) begin
          mul_a = px_s - MUL_W'(ux);
          mul_b = MUL_W'(vy) - MUL_W'(uy);
        end else begin
          mul_a = py_s - MUL_W'(uy);
          mul_b = MUL_W'(vx) - MUL_W'(ux);
        end
      end
      S_WGT: begin
        mul_a = {1'b0, a_chunk};
        mul_b = {1'b0, i_chunk};
      end
      S_DEPTH: begin
        case (op_r[1:0])
          2'd0:    mul_a = MUL_W'(vtx_r[V_AZ]);
          2'd1:    mul_a = MUL_W'(vtx_r[V_BZ]);
          default: mul_a = MUL_W'(vtx_r[V_CZ]);
        endcase
        mul_b = {1'b0, w_r[op_r[1:0]]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // align a weight partial product and accumulate
  always_comb begin
    sh_sel = {1'b0, ia_r} + {1'b0, ib_r};
    pp_ext = {68'b0, prod_r[33:0]};
    case (sh_sel)
      3'd0:    pp_sh = pp_ext;
      3'd1:    pp_sh = pp_ext << 17;
      3'd2:    pp_sh = pp_ext << 34;
      3'd3:    pp_sh = pp_ext << 51;
      default: pp_sh = pp_ext << 68;
    endcase
    wsum = ((ia_r == 2'd0 && ib_r == 2'd0) ? '0 : wacc_r) + pp_sh[AW-1:0];
  end

  // doubled area, edge signs, depth clamp
  always_comb begin
    area_d   = acc_r - 37'(prod_r);
    area_abs = (area_d < 0) ? 37'(-area_d) : 37'(area_d);
    in_tri   = (c_r[0] > 0 && c_r[1] > 0 && c_r[2] > 0) ||
               (c_r[0] < 0 && c_r[1] < 0 && c_r[2] < 0);
    go       = in_tri && (inv_r != '0);
    dfull    = dsum_r >>> 16;
    if (dfull > 36'sd32767) begin
      dclamp = 16'sh7FFF;
    end else if (dfull < -36'sd32768) begin
      dclamp = -16'sh8000;
    end else begin
      dclamp = dfull[VTX_W-1:0];
    end
    last_pt = (scan_x_r == box_max_x_r) && (scan_y_r == box_max_y_r);
  end

  // screen-clamped bounding box of the stored vertices
  always_comb begin
    xmin = vtx_r[V_AX];
    if (vtx_r[V_BX] < xmin) xmin = vtx_r[V_BX];
    if (vtx_r[V_CX] < xmin) xmin = vtx_r[V_CX];
    xmax = vtx_r[V_AX];
    if (vtx_r[V_BX] > xmax) xmax = vtx_r[V_BX];
    if (vtx_r[V_CX] > xmax) xmax = vtx_r[V_CX];
    ymin = vtx_r[V_AY];
    if (vtx_r[V_BY] < ymin) ymin = vtx_r[V_BY];
    if (vtx_r[V_CY] < ymin) ymin = vtx_r[V_CY];
    ymax = vtx_r[V_AY];
    if (vtx_r[V_BY] > ymax) ymax = vtx_r[V_BY];
    if (vtx_r[V_CY] > ymax) ymax = vtx_r[V_CY];
    fx0 = 13'(xmin >>> 4);
    fx1 = 13'(xmax >>> 4);
    fy0 = 13'(ymin >>> 4);
    fy1 = 13'(ymax >>> 4);
    lim_w = (scr_w_r == '0) ? SIZE_W'(1) : ((scr_w_r > SCR_LIM) ? SCR_LIM : scr_w_r);
    lim_h = (scr_h_r == '0) ? SIZE_W'(1) : ((scr_h_r > SCR_LIM) ? SCR_LIM : scr_h_r);
    wm1 = $signed({1'b0, lim_w}) - 14'sd1;
    hm1 = $signed({1'b0, lim_h}) - 14'sd1;
    bx0 = (fx0 < 0) ? '0 : ((14'(fx0) > wm1) ? wm1[PIX_W-1:0] : fx0[PIX_W-1:0]);
    bx1 = (fx1 < 0) ? '0 : ((14'(fx1) > wm1) ? wm1[PIX_W-1:0] : fx1[PIX_W-1:0]);
    by0 = (fy0 < 0) ? '0 : ((14'(fy0) > hm1) ? hm1[PIX_W-1:0] : fy0[PIX_W-1:0]);
    by1 = (fy1 < 0) ? '0 : ((14'(fy1) > hm1) ? hm1[PIX_W-1:0] : fy1[PIX_W-1:0]);
    box_off = (fx1 < 0) || (14'(fx0) > wm1) || (fy1 < 0) || (14'(fy0) > hm1) ||
              (bx0 > bx1) || (by0 > by1);
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ph_r          <= 1'b0;
      op_r          <= '0;
      wi_r          <= '0;
      ia_r          <= '0;
      ib_r          <= '0;
      scr_w_r       <= SIZE_W'(80);
      scr_h_r       <= SIZE_W'(24);
      max_depth_r   <= 16'sh7FFF;
      inv_r         <= '0;
      scan_x_r      <= '0;
      scan_y_r      <= '0;
      box_min_y_r   <= '0;
      box_max_x_r   <= '0;
      box_max_y_r   <= '0;
      walking_r     <= 1'b0;
      recip_start_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      recip_start_r <= 1'b0;

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:  scr_w_r     <= cfg_wdata[SIZE_W-1:0];
          CFG_SCREEN_HEIGHT: scr_h_r     <= cfg_wdata[SIZE_W-1:0];
          CFG_MAX_DEPTH:     max_depth_r <= cfg_wdata;
          default: ;
        endcase
      end

      // drop the result once taken, unless the final state replaces it
      if (out_valid_r && out_chan.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            act_r <= in_chan.data.action;
            if (in_chan.data.action == ACT_LOAD) begin
              vtx_r[V_AX] <= in_chan.data.vertex_a_x;
              vtx_r[V_AY] <= in_chan.data.vertex_a_y;
              vtx_r[V_AZ] <= in_chan.data.vertex_a_z;
              vtx_r[V_BX] <= in_chan.data.vertex_b_x;
              vtx_r[V_BY] <= in_chan.data.vertex_b_y;
              vtx_r[V_BZ] <= in_chan.data.vertex_b_z;
              vtx_r[V_CX] <= in_chan.data.vertex_c_x;
              vtx_r[V_CY] <= in_chan.data.vertex_c_y;
              vtx_r[V_CZ] <= in_chan.data.vertex_c_z;
            end
            state_r <= S_DECODE;
          end
        end

        S_DECODE: begin
          ph_r <= 1'b0;
          op_r <= '0;
          wi_r <= '0;
          ia_r <= '0;
          ib_r <= '0;
          if (act_r == ACT_LOAD) begin
            walking_r   <= !box_off;
            scan_x_r    <= bx0;
            scan_y_r    <= by0;
            box_min_y_r <= by0;
            box_max_x_r <= bx1;
            box_max_y_r <= by1;
            state_r     <= S_AREA;
          end else if (walking_r) begin
            state_r <= S_EDGE;
          end else begin
            state_r <= S_IDLE;
          end
        end

        S_AREA: begin
          ph_r <= !ph_r;
          if (!ph_r) begin
            prod_r <= prod;
          end else if (!op_r[0]) begin
            acc_r <= 37'(prod_r);
            op_r  <= op_r + 1'b1;
          end else begin
            div_in_r      <= area_abs[AD_W-1:0];
            recip_start_r <= 1'b1;
            state_r       <= S_DIV;
          end
        end

        S_DIV: begin
          if (recip_stat.done) begin
            inv_r   <= recip_stat.quot;
            state_r <= S_IDLE;
          end
        end

        S_EDGE: begin
          ph_r <= !ph_r;
          if (!ph_r) begin
            prod_r <= prod;
          end else begin
            if (!op_r[0]) begin
              acc_r <= 37'(prod_r);
            end else begin
              c_r[op_r[2:1]] <= acc_r - 37'(prod_r);
            end
            op_r <= op_r + 1'b1;
            if (op_r == 3'd5) begin
              op_r    <= '0;
              state_r <= S_WGT;
            end
          end
        end

        S_WGT: begin
          if (!go) begin
            state_r <= S_FIN;
          end else begin
            ph_r <= !ph_r;
            if (!ph_r) begin
              prod_r <= prod;
            end else begin
              wacc_r <= wsum;
              if (ib_r != 2'd2) begin
                ib_r <= ib_r + 1'b1;
              end else begin
                ib_r <= '0;
                if (ia_r != 2'd2) begin
                  ia_r <= ia_r + 1'b1;
                end else begin
                  ia_r      <= '0;
                  w_r[wi_r] <= wsum[WLSB +: CHUNK_W];
                  if (wi_r != 2'd2) begin
                    wi_r <= wi_r + 1'b1;
                  end else begin
                    state_r <= S_DEPTH;
                  end
                end
              end
            end
          end
        end

        S_DEPTH: begin
          ph_r <= !ph_r;
          if (!ph_r) begin
            prod_r <= prod;
          end else begin
            dsum_r <= ((op_r == 3'd0) ? 36'sd0 : dsum_r) + prod_r;
            op_r   <= op_r + 1'b1;
            if (op_r == 3'd2) begin
              state_r <= S_FIN;
            end
          end
        end

        S_FIN: begin
          // hold until the output register is free, then advance the walk
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r   <= 1'b1;
            out_r.covered <= go && (dclamp <= max_depth_r);
            out_r.pixel_x <= scan_x_r;
            out_r.pixel_y <= scan_y_r;
            out_r.depth   <= go ? dclamp : '0;
            out_r.last    <= last_pt;
            if (last_pt) begin
              walking_r <= 1'b0;
            end else if (scan_y_r < box_max_y_r) begin
              scan_y_r <= scan_y_r + 1'b1;
            end else begin
              scan_y_r <= box_min_y_r;
              scan_x_r <= scan_x_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  tbr_recip #(
    .FRAC_BITS (RECIP_FRAC_BITS)
  ) u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (recip_start_r),
    .divisor (div_in_r),
    .stat    (recip_stat)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

endmodule

// ===== rtl/tbr_checker.sv =====
// ----------------------------------------------------------------------------
// tbr_checker
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_bbox_rasterizer_defines.svh"

module tbr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tbr_pkg::tbr_out_t out_data
);
  import tbr_pkg::*;

  // an accepted request always takes the sequencer out of idle
  `TBR_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after request")

  // a new result appears only as the sequencer returns to idle
  `TBR_ASSERT_NOW(a_result_at_idle, $rose(out_valid), in_ready, "result while busy")

  // a stalled result stays offered
  `TBR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

  // a stalled result keeps its payload
  `TBR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed")

endmodule

bind triangle_bbox_rasterizer tbr_checker u_tbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

// ===== sim/triangle_bbox_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_bbox_rasterizer_tb
// Self-checking bench for the triangle rasterizer. A directed table of
// requests runs first, then random triangle loads and box walks under
// several screen and depth settings. Each accepted request advances an
// internal pixel predictor and every result is matched in order.
// ----------------------------------------------------------------------------
module triangle_bbox_rasterizer_tb;
  import tbr_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    tbr_in_t  req;
    bit       typed;
    bit       has_pix;
    tbr_out_t pix;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tbr_in_if  in_chan ();
  tbr_out_if out_chan ();

  triangle_bbox_rasterizer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic signed [VTX_W-1:0] vtx[9];
  longint unsigned         inv_area;
  longint                  scan_x, scan_y, box_min_y, box_max_x, box_max_y;
  bit                      walking;
  logic [SIZE_W-1:0]       scr_w, scr_h;
  logic signed [VTX_W-1:0] depth_lim;

  tbr_out_t pixel_q[$];
  int       errors;
  int       results_seen;
  bit       burst;

  always #HALF_PERIOD clk = ~clk;

  function automatic longint floor_pix(longint v);
    return v >>> 4;
  endfunction

  function automatic longint size_lim(logic [SIZE_W-1:0] r);
    longint s;
    s = r;
    if (s < 1) s = 1;
    if (s > 4096) s = 4096;
    return s;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint cross_z(longint px, longint py, longint ux, longint uy,
                                     longint vx, longint vy);
    return (px - ux) * (vy - uy) - (py - uy) * (vx - ux);
  endfunction

  function automatic longint unsigned absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int sgn(longint v);
    return v > 0 ? 1 : (v < 0 ? -1 : 0);
  endfunction

  function automatic tbr_in_t mk(logic act, int ax, int ay, int az, int bx, int by,
                                 int bz, int cx, int cy, int cz);
    tbr_in_t r;
    r.action = act;
    r.vertex_a_x = VTX_W'(ax); r.vertex_a_y = VTX_W'(ay); r.vertex_a_z = VTX_W'(az);
    r.vertex_b_x = VTX_W'(bx); r.vertex_b_y = VTX_W'(by); r.vertex_b_z = VTX_W'(bz);
    r.vertex_c_x = VTX_W'(cx); r.vertex_c_y = VTX_W'(cy); r.vertex_c_z = VTX_W'(cz);
    return r;
  endfunction

  function automatic tbr_out_t pix(bit cov, int x, int y, int d, bit lst);
    tbr_out_t p;
    p.covered = cov;
    p.pixel_x = PIX_W'(x);
    p.pixel_y = PIX_W'(y);
    p.depth   = VTX_W'(d);
    p.last    = lst;
    return p;
  endfunction

  // advance the pixel predictor by one request
  task automatic predict_pixel(input tbr_in_t r, output bit has, output tbr_out_t p);
    longint ax, ay, az, bx, by, bz, cx, cy, cz, d, w, h;
    longint mnx, mxx, mny, mxy, x0, x1, y0, y1;
    longint px, py, c1, c2, c3, w1, w2, w3, dep;
    longint unsigned ad;
    bit in_tri, cov, lst;
    has = 0;
    p = '0;
    if (r.action == ACT_LOAD) begin
      vtx[V_AX] = r.vertex_a_x; vtx[V_AY] = r.vertex_a_y; vtx[V_AZ] = r.vertex_a_z;
      vtx[V_BX] = r.vertex_b_x; vtx[V_BY] = r.vertex_b_y; vtx[V_BZ] = r.vertex_b_z;
      vtx[V_CX] = r.vertex_c_x; vtx[V_CY] = r.vertex_c_y; vtx[V_CZ] = r.vertex_c_z;
      ax = vtx[V_AX]; ay = vtx[V_AY]; bx = vtx[V_BX];
      by = vtx[V_BY]; cx = vtx[V_CX]; cy = vtx[V_CY];
      d = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
      ad = absv(d);
      if (ad == 0) inv_area = 0;
      else begin
        inv_area = (64'd1 << 32) / ad;
        if (inv_area > (64'd1 << 40) - 1) inv_area = (64'd1 << 40) - 1;
      end
      w = size_lim(scr_w);
      h = size_lim(scr_h);
      mnx = floor_pix(ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx));
      mxx = floor_pix(ax > bx ? (ax > cx ? ax : cx) : (bx > cx ? bx : cx));
      mny = floor_pix(ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy));
      mxy = floor_pix(ay > by ? (ay > cy ? ay : cy) : (by > cy ? by : cy));
      x0 = clampv(mnx, 0, w - 1); x1 = clampv(mxx, 0, w - 1);
      y0 = clampv(mny, 0, h - 1); y1 = clampv(mxy, 0, h - 1);
      if (mxx < 0 || mnx > w - 1 || mxy < 0 || mny > h - 1 || x0 > x1 || y0 > y1) begin
        walking = 0;
      end else begin
        scan_x = x0; scan_y = y0; box_min_y = y0;
        box_max_x = x1; box_max_y = y1;
        walking = 1;
      end
    end else if (walking) begin
      ax = vtx[V_AX]; ay = vtx[V_AY]; az = vtx[V_AZ];
      bx = vtx[V_BX]; by = vtx[V_BY]; bz = vtx[V_BZ];
      cx = vtx[V_CX]; cy = vtx[V_CY]; cz = vtx[V_CZ];
      px = scan_x * 16;
      py = scan_y * 16;
      c1 = cross_z(px, py, ax, ay, bx, by);
      c2 = cross_z(px, py, bx, by, cx, cy);
      c3 = cross_z(px, py, cx, cy, ax, ay);
      in_tri = sgn(c1) != 0 && sgn(c1) == sgn(c2) && sgn(c2) == sgn(c3);
      dep = 0;
      cov = 0;
      if (in_tri && inv_area != 0) begin
        w1 = longint'((absv(c2) * inv_area) >> 16);
        w2 = longint'((absv(c3) * inv_area) >> 16);
        w3 = longint'((absv(c1) * inv_area) >> 16);
        dep = clampv((az * w1 + bz * w2 + cz * w3) >>> 16, -32768, 32767);
        cov = dep <= longint'(depth_lim);
      end
      lst = scan_x == box_max_x && scan_y == box_max_y;
      p = pix(cov, int'(scan_x), int'(scan_y), int'(dep), lst);
      has = 1;
      if (lst) walking = 0;
      else if (scan_y < box_max_y) scan_y++;
      else begin
        scan_y = box_min_y;
        scan_x++;
      end
    end
  endtask

  // offer one request, hold until accepted, then record what it yields
  task automatic send_request(input tbr_in_t r, input bit typed, input bit t_has,
                              input tbr_out_t t_pix);
    int gap;
    bit has;
    tbr_out_t p;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.data  = r;
    in_chan.valid = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    predict_pixel(r, has, p);
    if (typed) begin
      has = t_has;
      p = t_pix;
    end
    if (has) pixel_q.push_back(p);
    @(negedge clk);
  endtask

  // write one register once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    in_chan.valid = 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SCREEN_WIDTH) scr_w = val[SIZE_W-1:0];
    else if (idx == CFG_SCREEN_HEIGHT) scr_h = val[SIZE_W-1:0];
    else if (idx == CFG_MAX_DEPTH) depth_lim = val;
  endtask

  function automatic tbr_in_t rand_step();
    tbr_in_t r;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(tbr_in_t)-1:0];
    r.action = ACT_STEP;
    return r;
  endfunction

  // small triangle near the visible area, sometimes anywhere at all
  function automatic tbr_in_t rand_load();
    tbr_in_t r;
    int bx, by, span;
    r = rand_step();
    r.action = ACT_LOAD;
    if ($urandom_range(0, 7) != 0) begin
      span = $urandom_range(16, 128);
      bx = $urandom_range(0, (size_lim(scr_w) > 40 ? 40 : size_lim(scr_w)) * 16) - 32;
      by = $urandom_range(0, (size_lim(scr_h) > 40 ? 40 : size_lim(scr_h)) * 16) - 32;
      r.vertex_a_x = VTX_W'(bx + int'($urandom_range(0, span)));
      r.vertex_a_y = VTX_W'(by + int'($urandom_range(0, span)));
      r.vertex_b_x = VTX_W'(bx + int'($urandom_range(0, span)));
      r.vertex_b_y = VTX_W'(by + int'($urandom_range(0, span)));
      r.vertex_c_x = VTX_W'(bx + int'($urandom_range(0, span)));
      r.vertex_c_y = VTX_W'(by + int'($urandom_range(0, span)));
    end
    return r;
  endfunction

  // take results, stall at random, check each against the oldest prediction
  initial begin
    tbr_out_t e, a;
    int n;
    bit held;
    held = 0;
    out_chan.ready = 1'b0;
    forever begin
      if (!held && results_seen == 60) begin
        out_chan.ready = 1'b0;
        repeat (400) @(negedge clk);
        held = 1;
      end
      n = burst ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_chan.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      a = out_chan.data;
      results_seen++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, a);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (a.covered !== e.covered || a.pixel_x !== e.pixel_x ||
            a.pixel_y !== e.pixel_y || a.depth !== e.depth || a.last !== e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, a);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    dir_row_t rows[$];
    logic [15:0] phase_cfg[5][3];
    tbr_out_t none;
    int steps, items;
    clk = 1'b0; rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_SCREEN_WIDTH; cfg_wdata = '0;
    in_chan.valid = 1'b0; in_chan.data = '0;
    errors = 0; results_seen = 0; burst = 0;
    scr_w = SIZE_W'(80); scr_h = SIZE_W'(24); depth_lim = 16'sh7fff;
    inv_area = 0; walking = 0;
    scan_x = 0; scan_y = 0; box_min_y = 0; box_max_x = 0; box_max_y = 0;
    foreach (vtx[i]) vtx[i] = '0;
    none = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed table: vertex, zero area, off screen, extremes, one-pixel box
    rows.push_back('{mk(ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none});
    rows.push_back('{mk(ACT_LOAD, 16, 16, 256, 80, 16, 256, 16, 80, 256), 1, 0, none});
    rows.push_back('{mk(ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, pix(0, 1, 1, 0, 0)});
    for (int i = 0; i < 6; i++) rows.push_back('{rand_step(), 0, 0, none});
    rows.push_back('{mk(ACT_LOAD, 0, 0, 100, 32, 32, 200, 64, 64, 300), 1, 0, none});
    rows.push_back('{mk(ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, pix(0, 0, 0, 0, 0)});
    rows.push_back('{mk(ACT_LOAD, -32768, 0, 0, -32000, 16, 0, -32768, 32, 0), 1, 0, none});
    rows.push_back('{mk(ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none});
    rows.push_back('{mk(ACT_LOAD, -32768, -32768, -32768, 32767, -32768, 32767,
                        -32768, 32767, 32767), 0, 0, none});
    for (int i = 0; i < 5; i++) rows.push_back('{rand_step(), 0, 0, none});
    rows.push_back('{mk(ACT_LOAD, 16, 16, 0, 20, 16, 0, 16, 20, 0), 1, 0, none});
    rows.push_back('{mk(ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1, pix(0, 1, 1, 0, 1)});
    rows.push_back('{mk(ACT_STEP, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1, 0, none});
    rows.push_back('{mk(ACT_LOAD, 0, 0, 32767, 1200, 0, 32767, 0, 380, 32767), 0, 0, none});
    for (int i = 0; i < 3; i++) rows.push_back('{rand_step(), 0, 0, none});
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].has_pix,
                                   rows[i].pix);

    // screen and depth settings, extremes included
    phase_cfg = '{'{16'd80, 16'd24, 16'h7fff}, '{16'd1, 16'd1, 16'h8000},
                  '{16'd4096, 16'd4096, 16'h0000}, '{16'd8191, 16'd0, 16'h0200},
                  '{16'd16, 16'd8, 16'hff00}};
    write_reg(2'd3, 16'hffff);
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_SCREEN_WIDTH, phase_cfg[ph][0]);
      write_reg(CFG_SCREEN_HEIGHT, phase_cfg[ph][1]);
      write_reg(CFG_MAX_DEPTH, phase_cfg[ph][2]);
      items = 0;
      while (items < 60) begin
        burst = ($urandom_range(0, 3) == 0);
        send_request(rand_load(), 0, 0, none);
        steps = $urandom_range(1, 40);
        for (int s = 0; s < steps; s++) send_request(rand_step(), 0, 0, none);
        items += steps + 1;
      end
    end
    burst = 0;
    in_chan.valid = 1'b0;

    while (pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("** triangle_bbox_rasterizer: PASSED **");
    else $display("** triangle_bbox_rasterizer: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #(2 * HALF_PERIOD * 1000000);
    $display("** triangle_bbox_rasterizer: FAILED **");
    $finish;
  end

endmodule
